>>> rtl/ssr_pkg.sv
// Shared types, constants and helpers for the substring replace stream block.
// Used by the window and emit cells, the output stage and the top level.
`default_nettype none

package ssr_pkg;

	// Default sizes of the match window and the replacement text, in bytes.
	localparam int MAX_PATTERN_DEF     = 8;
	localparam int MAX_REPLACEMENT_DEF = 8;

	// Width of lengths and fill counts as they travel between modules.
	localparam int CNT_W = 4;

	// Configuration port geometry.
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 64;

	localparam logic [15:0] CAPACITY_RESET = 16'd512;

	// Register indexes of the configuration port.
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PATTERN_BYTES      = 3'd0,
		REG_PATTERN_LENGTH     = 3'd1,
		REG_REPLACEMENT_BYTES  = 3'd2,
		REG_REPLACEMENT_LENGTH = 3'd3,
		REG_OUTPUT_CAPACITY    = 3'd4
	} cfg_reg_t;

	// Payload of one input item.
	typedef struct packed {
		logic [7:0] in_byte;
		logic       end_of_string;
	} in_item_t;

	// Payload of one result item.
	typedef struct packed {
		logic [7:0] out_byte;
		logic       last_out;
		logic       overflow;
		logic       none_found;
	} out_item_t;

	// Payload of one configuration write.
	typedef struct packed {
		logic [CFG_IDX_W-1:0]  reg_index;
		logic [CFG_DATA_W-1:0] wdata;
	} cfg_item_t;

	// What a window cell does at the next clock edge.
	typedef enum logic [1:0] {
		WIN_HOLD  = 2'd0,
		WIN_LOAD  = 2'd1,
		WIN_SHIFT = 2'd2,
		WIN_CLEAR = 2'd3
	} win_mode_t;

	// Control shared by every window cell.
	typedef struct packed {
		win_mode_t        mode;
		logic [CNT_W-1:0] fill_cut;
		logic [CNT_W-1:0] plen;
		logic [7:0]       in_byte;
	} win_ctrl_t;

	// What an emit cell does at the next clock edge.
	typedef enum logic [1:0] {
		EMIT_HOLD  = 2'd0,
		EMIT_LOAD  = 2'd1,
		EMIT_SHIFT = 2'd2
	} emit_mode_t;

	// Head of the emit queue as seen by the output stage.
	typedef struct packed {
		logic       avail;
		logic [7:0] head_byte;
		logic       last;
		logic       none_found;
	} emit_head_t;

	// A length of zero acts as one, a length above the maximum acts as the maximum.
	function automatic logic [CNT_W-1:0] clamp_len(input logic [CNT_W-1:0] len,
			input logic [CNT_W-1:0] max_len);
		logic [CNT_W-1:0] r;
		r = len;
		if (len == '0) begin
			r = CNT_W'(1);
		end else if (len > max_len) begin
			r = max_len;
		end
		return r;
	endfunction

endpackage

`default_nettype wire

>>> rtl/ssr_stream_if.sv
// Valid/ready channel used for the input, result and configuration streams.
// The payload type is a parameter; the block uses the structs of ssr_pkg.
`default_nettype none

interface ssr_stream_if #(
	parameter type payload_t = logic
) ();
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> rtl/ssr_win_cell.sv
// One byte of the match window, with its compare against the pattern byte.
// Depends on ssr_pkg; chained by the top level, each cell takes its upper neighbor's byte on a shift.
`default_nettype none

module ssr_win_cell #(
	parameter int POS = 0
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire ssr_pkg::win_ctrl_t ctrl,
	input  wire logic [7:0]        pat_byte,
	input  wire logic [7:0]        next_cand,
	output logic [7:0]             cand,
	output logic                   eq
);
	import ssr_pkg::*;

	localparam logic [CNT_W-1:0] POS_C = CNT_W'(POS);

	logic [7:0] byte_q;

	// Window content after the new byte is placed: older bytes stay, the new one
	// lands at the cut fill position, and cells above it read as empty.
	always_comb begin
		if (POS_C < ctrl.fill_cut) begin
			cand = byte_q;
		end else if (POS_C == ctrl.fill_cut) begin
			cand = ctrl.in_byte;
		end else begin
			cand = 8'd0;
		end
	end

	// Cells beyond the pattern length always agree.
	assign eq = (POS_C >= ctrl.plen) || (cand == pat_byte);

	// Next content of the cell.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_q <= 8'd0;
		end else begin
			case (ctrl.mode)
				WIN_LOAD:  byte_q <= cand;
				WIN_SHIFT: byte_q <= next_cand;
				WIN_CLEAR: byte_q <= 8'd0;
				default:   byte_q <= byte_q;
			endcase
		end
	end

endmodule

`default_nettype wire

>>> rtl/ssr_emit_cell.sv
// One byte of the emit queue that holds the pending results of an item.
// Depends on ssr_pkg; chained by the top level, each cell takes its upper neighbor's byte on a shift.
`default_nettype none

module ssr_emit_cell (
	input  wire logic               clk,
	input  wire ssr_pkg::emit_mode_t mode,
	input  wire logic [7:0]         load_byte,
	input  wire logic [7:0]         next_byte,
	output logic [7:0]              held
);
	import ssr_pkg::*;

	logic [7:0] byte_q;

	// Load a fresh result byte, or move one place toward the head.
	always_ff @(posedge clk) begin
		case (mode)
			EMIT_LOAD:  byte_q <= load_byte;
			EMIT_SHIFT: byte_q <= next_byte;
			default:    byte_q <= byte_q;
		endcase
	end

	assign held = byte_q;

endmodule

`default_nettype wire

>>> rtl/ssr_out_stage.sv
// Output register with the per-string capacity count and overflow flag.
// Depends on ssr_pkg and ssr_stream_if; takes bytes from the head of the emit queue.
`default_nettype none

module ssr_out_stage (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic [15:0]         capacity,
	input  wire ssr_pkg::emit_head_t head,
	output logic                     take,
	ssr_stream_if.source             out_item
);
	import ssr_pkg::*;

	logic [15:0] written_q;
	logic        ovf_q;
	logic        valid_q;
	out_item_t   data_q;
	logic [15:0] room;
	logic        fits;
	logic        ovf_now;

	// One slot of the capacity is kept for the terminator.
	assign room    = (capacity == 16'd0) ? 16'd0 : capacity - 16'd1;
	assign fits    = written_q < room;
	assign ovf_now = ovf_q || !fits;

	// A byte moves in when the register is empty or its item is being taken.
	assign take = head.avail && (!valid_q || out_item.ready);

	// Control: valid flag, byte count and overflow, cleared after the last item of a string.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q   <= 1'b0;
			written_q <= 16'd0;
			ovf_q     <= 1'b0;
		end else if (take) begin
			valid_q <= 1'b1;
			if (head.last) begin
				written_q <= 16'd0;
				ovf_q     <= 1'b0;
			end else begin
				if (fits) begin
					written_q <= written_q + 16'd1;
				end
				ovf_q <= ovf_now;
			end
		end else if (out_item.ready) begin
			valid_q <= 1'b0;
		end
	end

	// Result payload; a byte beyond the capacity goes out as zero.
	always_ff @(posedge clk) begin
		if (take) begin
			data_q.out_byte   <= fits ? head.head_byte : 8'd0;
			data_q.last_out   <= head.last;
			data_q.overflow   <= ovf_now;
			data_q.none_found <= head.last && head.none_found;
		end
	end

	assign out_item.valid = valid_q;
	assign out_item.data  = data_q;

endmodule

`default_nettype wire

>>> rtl/substring_replace_stream.sv
// Streaming find-and-replace on a byte string.
// Channels: in_item carries in_byte and end_of_string, out_item carries out_byte,
// last_out, overflow and none_found, cfg writes the five registers by index.
// All three are valid/ready; an item moves when both are high at a clock edge.
// A row of window cells holds the last bytes and compares them with the pattern;
// a row of emit cells holds the result bytes an item causes and shifts them out.
// The first result of an item is loaded into the emit row when the item is taken and
// moves from there into the output register that drives out_item.
// Throughput: with out_item ready, one item per cycle while each item causes at most one result.
// An item that causes n results (a replacement, or the flush at end of string)
// holds in_item.ready low until the emit row hands over its last byte, one byte
// per cycle through the single output register while out_item is ready.
// When the receiver stalls, the output register holds its item, the emit row
// holds its bytes and in_item.ready stays low while the emit row holds any byte.
// Reset clears the window, the counters and the flags and sets the registers to
// pattern length 1, replacement length 1 and capacity 512; cfg is always ready.
// Configuration is meant to be written only while no string is in flight.
// Depends on ssr_pkg, ssr_stream_if, ssr_win_cell, ssr_emit_cell and ssr_out_stage.
`default_nettype none

module substring_replace_stream #(
	parameter int MAX_PATTERN     = ssr_pkg::MAX_PATTERN_DEF,
	parameter int MAX_REPLACEMENT = ssr_pkg::MAX_REPLACEMENT_DEF
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	ssr_stream_if.sink   in_item,
	ssr_stream_if.sink   cfg,
	ssr_stream_if.source out_item
);
	import ssr_pkg::*;

	localparam int EMIT_DEPTH = (MAX_PATTERN > MAX_REPLACEMENT) ? MAX_PATTERN : MAX_REPLACEMENT;
	localparam int FILL_W     = $clog2(MAX_PATTERN + 1);
	localparam int ECNT_W     = $clog2(EMIT_DEPTH + 1);

	// Configuration registers.
	logic [63:0]      pat_q;
	logic [CNT_W-1:0] plen_cfg_q;
	logic [63:0]      repl_q;
	logic [CNT_W-1:0] rlen_cfg_q;
	logic [15:0]      cap_q;

	// Window and string state.
	logic [FILL_W-1:0] fill_q;
	logic              any_q;

	// Emit queue state.
	logic [ECNT_W-1:0] cnt_q;
	logic              last_q;
	logic              nf_q;

	logic [CNT_W-1:0]  plen;
	logic [CNT_W-1:0]  rlen;
	logic [CNT_W-1:0]  fill_x;
	logic [CNT_W-1:0]  fill_cut;
	logic              full;
	logic              match;
	logic              hit;
	logic              eos;
	logic              in_acc;
	logic              take;
	logic [ECNT_W-1:0] n_emit;
	win_ctrl_t         win_ctrl;
	emit_mode_t        emit_mode;
	emit_head_t        head;

	logic [7:0]             cand_v [MAX_PATTERN];
	logic [MAX_PATTERN-1:0] eq_v;
	logic [7:0]             emit_v [EMIT_DEPTH];

	// Configuration writes; indexes beyond the list are ignored.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_q      <= 64'd0;
			plen_cfg_q <= CNT_W'(1);
			repl_q     <= 64'd0;
			rlen_cfg_q <= CNT_W'(1);
			cap_q      <= CAPACITY_RESET;
		end else if (cfg.valid) begin
			case (cfg.data.reg_index)
				REG_PATTERN_BYTES:      pat_q      <= cfg.data.wdata;
				REG_PATTERN_LENGTH:     plen_cfg_q <= cfg.data.wdata[CNT_W-1:0];
				REG_REPLACEMENT_BYTES:  repl_q     <= cfg.data.wdata;
				REG_REPLACEMENT_LENGTH: rlen_cfg_q <= cfg.data.wdata[CNT_W-1:0];
				REG_OUTPUT_CAPACITY:    cap_q      <= cfg.data.wdata[15:0];
				default:                ;
			endcase
		end
	end

	assign plen = clamp_len(plen_cfg_q, CNT_W'(MAX_PATTERN));
	assign rlen = clamp_len(rlen_cfg_q, CNT_W'(MAX_REPLACEMENT));

	// Window bookkeeping for the incoming byte.
	assign in_acc   = in_item.valid && in_item.ready;
	assign eos      = in_item.data.end_of_string;
	assign fill_x   = CNT_W'(fill_q);
	assign fill_cut = (fill_x >= plen) ? plen - CNT_W'(1) : fill_x;
	assign full     = (fill_cut + CNT_W'(1)) == plen;
	assign match    = &eq_v;
	assign hit      = full && match;

	always_comb begin
		win_ctrl.fill_cut = fill_cut;
		win_ctrl.plen     = plen;
		win_ctrl.in_byte  = in_item.data.in_byte;
		if (!in_acc) begin
			win_ctrl.mode = WIN_HOLD;
		end else if (eos || hit) begin
			win_ctrl.mode = WIN_CLEAR;
		end else if (full) begin
			win_ctrl.mode = WIN_SHIFT;
		end else begin
			win_ctrl.mode = WIN_LOAD;
		end
	end

	// Row of window cells.
	for (genvar i = 0; i < MAX_PATTERN; i++) begin : g_win
		logic [7:0] next_cand;
		if (i == MAX_PATTERN - 1) begin : g_top
			assign next_cand = 8'd0;
		end else begin : g_mid
			assign next_cand = cand_v[i+1];
		end
		ssr_win_cell #(
			.POS (i)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctrl      (win_ctrl),
			.pat_byte  (pat_q[8*i +: 8]),
			.next_cand (next_cand),
			.cand      (cand_v[i]),
			.eq        (eq_v[i])
		);
	end

	// Fill count and the replaced-anything flag of the current string.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			any_q  <= 1'b0;
		end else if (in_acc) begin
			case (win_ctrl.mode)
				WIN_CLEAR: fill_q <= '0;
				WIN_SHIFT: fill_q <= FILL_W'(fill_cut);
				default:   fill_q <= FILL_W'(fill_cut + CNT_W'(1));
			endcase
			if (eos) begin
				any_q <= 1'b0;
			end else if (hit) begin
				any_q <= 1'b1;
			end
		end
	end

	// Number of result bytes this item causes.
	always_comb begin
		if (hit) begin
			n_emit = ECNT_W'(rlen);
		end else if (full) begin
			n_emit = eos ? ECNT_W'(plen) : ECNT_W'(1);
		end else if (eos) begin
			n_emit = ECNT_W'(fill_cut + CNT_W'(1));
		end else begin
			n_emit = '0;
		end
	end

	// A new item enters once the emit row is empty or hands over its last byte.
	assign in_item.ready = (cnt_q == '0) || ((cnt_q == ECNT_W'(1)) && take);

	always_comb begin
		if (in_acc) begin
			emit_mode = EMIT_LOAD;
		end else if (take) begin
			emit_mode = EMIT_SHIFT;
		end else begin
			emit_mode = EMIT_HOLD;
		end
	end

	// Row of emit cells: replacement text on a hit, else the window from its oldest byte.
	for (genvar j = 0; j < EMIT_DEPTH; j++) begin : g_emit
		logic [7:0] repl_byte;
		logic [7:0] win_byte;
		logic [7:0] next_byte;
		if (j < MAX_REPLACEMENT) begin : g_repl
			assign repl_byte = repl_q[8*j +: 8];
		end else begin : g_norepl
			assign repl_byte = 8'd0;
		end
		if (j < MAX_PATTERN) begin : g_wb
			assign win_byte = cand_v[j];
		end else begin : g_nowb
			assign win_byte = 8'd0;
		end
		if (j == EMIT_DEPTH - 1) begin : g_top
			assign next_byte = 8'd0;
		end else begin : g_mid
			assign next_byte = emit_v[j+1];
		end
		ssr_emit_cell u_cell (
			.clk       (clk),
			.mode      (emit_mode),
			.load_byte (hit ? repl_byte : win_byte),
			.next_byte (next_byte),
			.held      (emit_v[j])
		);
	end

	// Emit queue count and the end-of-string flags of its item.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			last_q <= 1'b0;
			nf_q   <= 1'b0;
		end else if (in_acc) begin
			cnt_q  <= n_emit;
			last_q <= eos;
			nf_q   <= eos && !(any_q || hit);
		end else if (take) begin
			cnt_q <= cnt_q - ECNT_W'(1);
		end
	end

	always_comb begin
		head.avail      = cnt_q != '0;
		head.head_byte  = emit_v[0];
		head.last       = last_q && (cnt_q == ECNT_W'(1));
		head.none_found = nf_q;
	end

	ssr_out_stage u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.capacity (cap_q),
		.head     (head),
		.take     (take),
		.out_item (out_item)
	);

	// The emit row never holds more bytes than it has cells.
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= ECNT_W'(EMIT_DEPTH))
		else $error("emit count exceeds the emit row");

	// The end of a string empties the window and always leaves at least one result.
	a_eos_flush: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && eos |=> (fill_q == '0) && (cnt_q != '0))
		else $error("end of string did not flush the window");

	// Once over capacity, every result byte goes out as zero.
	a_ovf_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_item.valid && out_item.data.overflow |-> out_item.data.out_byte == 8'd0)
		else $error("byte passed after overflow");

	// The no-match flag only appears on the final result of a string.
	a_nf_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_item.valid && out_item.data.none_found |-> out_item.data.last_out)
		else $error("none_found outside the final result");

	// The window never claims more bytes than it has cells.
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		CNT_W'(fill_q) <= CNT_W'(MAX_PATTERN))
		else $error("window fill exceeds the window");

endmodule

`default_nettype wire
